/* rtl/nubx_pkg.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// nubx_pkg: shared types and constants for the NMEA/UBX frame receiver
// Parser modes, event codes, framing bytes and the hex digit decoder.
// ----------------------------------------------------------------------------
package nubx_pkg;

  // Framing characters
  localparam logic [7:0] NMEA_START = 8'h24;  // '$'
  localparam logic [7:0] NMEA_STAR  = 8'h2A;  // '*'
  localparam logic [7:0] UBX_SYNC1  = 8'hB5;
  localparam logic [7:0] UBX_SYNC2  = 8'h62;
  localparam logic [7:0] CHAR_NINE  = 8'h39;  // '9'
  localparam logic [7:0] CHAR_UPPER_A = 8'h41;  // 'A'
  localparam logic [7:0] CHAR_ZERO  = 8'h30;  // '0'

  localparam logic [15:0] NMEA_COUNT_MAX = 16'hFFFF;

  // Parser modes
  typedef enum logic [2:0] {
    MODE_WAIT  = 3'd0,
    MODE_SYNC2 = 3'd1,
    MODE_NBODY = 3'd2,
    MODE_NHEX1 = 3'd3,
    MODE_NHEX2 = 3'd4,
    MODE_UHEAD = 3'd5,
    MODE_UBODY = 3'd6
  } mode_t;

  // Event codes
  typedef enum logic [2:0] {
    EV_NMEA_BYTE = 3'd0,
    EV_NMEA_GOOD = 3'd1,
    EV_NMEA_BAD  = 3'd2,
    EV_UBX_BYTE  = 3'd3,
    EV_UBX_GOOD  = 3'd4,
    EV_UBX_BAD   = 3'd5
  } event_t;

  // One result from the parser
  typedef struct packed {
    logic        valid;
    event_t      ev;
    logic [7:0]  data;
    logic [7:0]  ubx_class;
    logic [7:0]  msg_id;
    logic [15:0] length;
  } result_t;

  // Hex digit decode with 32-bit wrap and no validity test
  function automatic logic [31:0] nibble_of(input logic [7:0] d);
    logic [31:0] dw;
    dw = {24'd0, d};
    if (d > CHAR_NINE) begin
      return dw - {24'd0, CHAR_UPPER_A} + 32'd10;
    end
    return dw - {24'd0, CHAR_ZERO};
  endfunction

endpackage

/* rtl/nubx_parser.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// nubx_parser: byte-wise framing state machine
// Holds the frame state, updates it on each accepted byte and presents the
// result that the byte causes, combinationally, for the output register.
// ----------------------------------------------------------------------------
module nubx_parser (
  input  logic              clk,
  input  logic              rst,
  input  logic              accept,
  input  logic [7:0]        rx_byte,
  output nubx_pkg::result_t res
);

  nubx_pkg::mode_t mode, mode_next;
  logic [7:0]  nmea_xor, nmea_xor_next;
  logic [7:0]  first_hex_digit, first_hex_digit_next;
  logic [15:0] nmea_count, nmea_count_next;
  logic [7:0]  sum_a, sum_a_next;
  logic [7:0]  sum_b, sum_b_next;
  logic [16:0] ubx_count, ubx_count_next;
  logic [15:0] payload_length, payload_length_next;
  logic [7:0]  class_byte, class_byte_next;
  logic [7:0]  id_byte, id_byte_next;
  logic [7:0]  got_sum_a, got_sum_a_next;

  logic [7:0]  fl_a, fl_b;
  logic [16:0] pos;
  logic [31:0] hex_val;

  // Fletcher step, payload position and received checksum value
  assign fl_a    = sum_a + rx_byte;
  assign fl_b    = sum_b + fl_a;
  assign pos     = ubx_count - 17'd4;
  assign hex_val = (nubx_pkg::nibble_of(first_hex_digit) << 4)
                 | nubx_pkg::nibble_of(rx_byte);

  // State register
  always_ff @(posedge clk) begin
    if (rst) begin
      mode            <= nubx_pkg::MODE_WAIT;
      nmea_xor        <= '0;
      first_hex_digit <= '0;
      nmea_count      <= '0;
      sum_a           <= '0;
      sum_b           <= '0;
      ubx_count       <= '0;
      payload_length  <= '0;
      class_byte      <= '0;
      id_byte         <= '0;
      got_sum_a       <= '0;
    end else if (accept) begin
      mode            <= mode_next;
      nmea_xor        <= nmea_xor_next;
      first_hex_digit <= first_hex_digit_next;
      nmea_count      <= nmea_count_next;
      sum_a           <= sum_a_next;
      sum_b           <= sum_b_next;
      ubx_count       <= ubx_count_next;
      payload_length  <= payload_length_next;
      class_byte      <= class_byte_next;
      id_byte         <= id_byte_next;
      got_sum_a       <= got_sum_a_next;
    end
  end

  // Next state and result
  always_comb begin
    mode_next            = mode;
    nmea_xor_next        = nmea_xor;
    first_hex_digit_next = first_hex_digit;
    nmea_count_next      = nmea_count;
    sum_a_next           = sum_a;
    sum_b_next           = sum_b;
    ubx_count_next       = ubx_count;
    payload_length_next  = payload_length;
    class_byte_next      = class_byte;
    id_byte_next         = id_byte;
    got_sum_a_next       = got_sum_a;
    res                  = '0;

    unique case (mode)
      nubx_pkg::MODE_WAIT: begin
        if (rx_byte == nubx_pkg::NMEA_START) begin
          nmea_xor_next   = '0;
          nmea_count_next = '0;
          mode_next       = nubx_pkg::MODE_NBODY;
        end else if (rx_byte == nubx_pkg::UBX_SYNC1) begin
          mode_next = nubx_pkg::MODE_SYNC2;
        end
      end

      nubx_pkg::MODE_SYNC2: begin
        if (rx_byte == nubx_pkg::UBX_SYNC2) begin
          sum_a_next          = '0;
          sum_b_next          = '0;
          ubx_count_next      = '0;
          payload_length_next = '0;
          class_byte_next     = '0;
          id_byte_next        = '0;
          got_sum_a_next      = '0;
          mode_next           = nubx_pkg::MODE_UHEAD;
        end else begin
          mode_next = nubx_pkg::MODE_WAIT;
        end
      end

      // NMEA body: emit and fold into the XOR sum until '*'
      nubx_pkg::MODE_NBODY: begin
        if (rx_byte == nubx_pkg::NMEA_STAR) begin
          mode_next = nubx_pkg::MODE_NHEX1;
        end else begin
          nmea_xor_next = nmea_xor ^ rx_byte;
          if (nmea_count != nubx_pkg::NMEA_COUNT_MAX) begin
            nmea_count_next = nmea_count + 16'd1;
          end
          res.valid  = 1'b1;
          res.ev     = nubx_pkg::EV_NMEA_BYTE;
          res.data   = rx_byte;
          res.length = nmea_count_next;
        end
      end

      nubx_pkg::MODE_NHEX1: begin
        first_hex_digit_next = rx_byte;
        mode_next            = nubx_pkg::MODE_NHEX2;
      end

      nubx_pkg::MODE_NHEX2: begin
        mode_next  = nubx_pkg::MODE_WAIT;
        res.valid  = 1'b1;
        res.ev     = (hex_val == {24'd0, nmea_xor}) ? nubx_pkg::EV_NMEA_GOOD
                                                    : nubx_pkg::EV_NMEA_BAD;
        res.length = nmea_count;
      end

      // UBX header: class, id, length low, length high
      nubx_pkg::MODE_UHEAD: begin
        sum_a_next = fl_a;
        sum_b_next = fl_b;
        unique case (ubx_count)
          17'd0: class_byte_next = rx_byte;
          17'd1: id_byte_next = rx_byte;
          17'd2: payload_length_next = {8'd0, rx_byte};
          default: begin
            payload_length_next = {rx_byte, payload_length[7:0]};
            mode_next           = nubx_pkg::MODE_UBODY;
          end
        endcase
        ubx_count_next = ubx_count + 17'd1;
      end

      // UBX payload, then CK_A and CK_B
      nubx_pkg::MODE_UBODY: begin
        ubx_count_next = ubx_count + 17'd1;
        res.ubx_class  = class_byte;
        res.msg_id     = id_byte;
        res.length     = payload_length;
        if (pos < {1'b0, payload_length}) begin
          sum_a_next = fl_a;
          sum_b_next = fl_b;
          res.valid  = 1'b1;
          res.ev     = nubx_pkg::EV_UBX_BYTE;
          res.data   = rx_byte;
        end else if (pos == {1'b0, payload_length}) begin
          got_sum_a_next = rx_byte;
        end else begin
          mode_next = nubx_pkg::MODE_WAIT;
          res.valid = 1'b1;
          res.ev    = (got_sum_a == sum_a && rx_byte == sum_b) ? nubx_pkg::EV_UBX_GOOD
                                                               : nubx_pkg::EV_UBX_BAD;
        end
      end

      default: begin
        mode_next = nubx_pkg::MODE_WAIT;
      end
    endcase
  end

endmodule

/* rtl/nmea_ubx_frame_receiver.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// nmea_ubx_frame_receiver: NMEA sentence and UBX frame splitter
// A result appears in the cycle after the byte that causes it is accepted.
// Throughput: one byte per cycle while the full output register is not stalled.
// A new byte is taken while the output register drains in the same cycle.
// Reset (synchronous, active high): parser waits for a start byte, all
// sums and counters cleared, output register empty.
// ----------------------------------------------------------------------------
module nmea_ubx_frame_receiver (
  input  logic        clk,
  input  logic        rst,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic [7:0]  rx_byte,
  output logic        out_valid,
  input  logic        out_stall,
  output logic [2:0]  event_res,
  output logic [7:0]  data_byte,
  output logic [7:0]  ubx_class,
  output logic [7:0]  msg_id,
  output logic [15:0] frame_length
);

  nubx_pkg::result_t res;
  logic              in_acc;

  // Take a request when the output register is free or draining
  assign in_stall = out_valid && out_stall;
  assign in_acc   = in_valid && !in_stall;

  nubx_parser u_parser (
    .clk     (clk),
    .rst     (rst),
    .accept  (in_acc),
    .rx_byte (rx_byte),
    .res     (res)
  );

  // Output register: control
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (in_acc) begin
      out_valid <= res.valid;
    end else if (!out_stall) begin
      out_valid <= 1'b0;
    end
  end

  // Output register: payload
  always_ff @(posedge clk) begin
    if (in_acc && res.valid) begin
      event_res    <= res.ev;
      data_byte    <= res.data;
      ubx_class    <= res.ubx_class;
      msg_id       <= res.msg_id;
      frame_length <= res.length;
    end
  end

  // Checks
  a_stall_only_when_full: assert property (@(posedge clk) disable iff (rst)
    in_stall |-> out_valid)
    else $error("input stalled with empty output register");

  a_event_range: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> (event_res <= 3'(nubx_pkg::EV_UBX_BAD)))
    else $error("event code out of range");

  a_nmea_no_header: assert property (@(posedge clk) disable iff (rst)
    (out_valid && (event_res == 3'(nubx_pkg::EV_NMEA_BYTE)
                || event_res == 3'(nubx_pkg::EV_NMEA_GOOD)
                || event_res == 3'(nubx_pkg::EV_NMEA_BAD)))
    |-> (ubx_class == 8'd0 && msg_id == 8'd0))
    else $error("NMEA result carries UBX header fields");

  a_end_no_data: assert property (@(posedge clk) disable iff (rst)
    (out_valid && (event_res == 3'(nubx_pkg::EV_NMEA_GOOD)
                || event_res == 3'(nubx_pkg::EV_NMEA_BAD)
                || event_res == 3'(nubx_pkg::EV_UBX_GOOD)
                || event_res == 3'(nubx_pkg::EV_UBX_BAD)))
    |-> (data_byte == 8'd0))
    else $error("frame end result carries a data byte");

endmodule
